@@ hw/rtl/etc1_pkg.sv @@
// Shared types, constants and the modifier table of the ETC1 tiled block decoder.
`timescale 1ns / 1ps

package etc1_pkg;

  localparam int MAX_DIMENSION_DEF = 1024;
  localparam int DIM_W             = 11;
  localparam int COORD_W           = 10;
  localparam int CH_W              = 8;
  localparam int WORD_W            = 64;
  localparam int REG_IDX_W         = 2;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd8;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd8;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             alpha_present;
  } etc1_cfg_t;

  // One non-empty block as handed from the front to the back.
  typedef struct packed {
    logic [1:0][2:0][CH_W-1:0] base;      // [subblock][channel r,g,b]
    logic [1:0][2:0]           tab;       // modifier table per subblock
    logic                      flip;
    logic [31:0]               pix_bits;  // low word: selector and sign bits
    logic [WORD_W-1:0]         alphas;
    logic [COORD_W-1:0]        x0;
    logic [COORD_W-1:0]        y0;
    logic [1:0]                last_col;  // last visible column in the block
    logic [1:0]                last_row;  // last visible row in the block
  } etc1_cmd_t;

  function automatic logic [CH_W-1:0] mod_amount(input logic [2:0] tab, input logic sel);
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] hi;
    case (tab)
      3'd0: begin lo = 8'd2;  hi = 8'd8;   end
      3'd1: begin lo = 8'd5;  hi = 8'd17;  end
      3'd2: begin lo = 8'd9;  hi = 8'd29;  end
      3'd3: begin lo = 8'd13; hi = 8'd42;  end
      3'd4: begin lo = 8'd18; hi = 8'd60;  end
      3'd5: begin lo = 8'd24; hi = 8'd80;  end
      3'd6: begin lo = 8'd33; hi = 8'd106; end
      default: begin lo = 8'd47; hi = 8'd183; end
    endcase
    return sel ? hi : lo;
  endfunction

endpackage

@@ hw/rtl/etc1_front.sv @@
// Front end: accepts blocks, decodes base colors, tracks tile position and clips.
`timescale 1ns / 1ps

module etc1_front #(
  parameter int MAX_DIMENSION = etc1_pkg::MAX_DIMENSION_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  etc1_pkg::etc1_cfg_t        cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [etc1_pkg::WORD_W-1:0] color_word,
  input  logic [etc1_pkg::WORD_W-1:0] alpha_word,
  input  logic                       q_full,
  output logic                       q_push,
  output etc1_pkg::etc1_cmd_t        q_cmd
);
  import etc1_pkg::*;

  localparam int TILES_MAX = (MAX_DIMENSION + 7) / 8;
  localparam int TW        = (TILES_MAX > 1) ? $clog2(TILES_MAX) : 1;
  localparam int CW        = TW + 3;
  localparam int CMPW      = (CW > DIM_W) ? CW : DIM_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > MAX_DIMENSION) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

  // Smallest power of two not below ceil(d/8).
  function automatic logic [TW:0] pad_tiles(input logic [DIM_W-1:0] d);
    logic [DIM_W:0] t;
    logic [TW:0]    p;
    t = ({1'b0, d} + (DIM_W+1)'(7)) >> 3;
    p = '0;
    for (int i = TW; i >= 0; i--) begin
      if ((1 << i) >= int'(t)) p = (TW+1)'(1) << i;
    end
    return p;
  endfunction

  logic [TW-1:0]    tile_column;
  logic [TW-1:0]    tile_row;
  logic [1:0]       block_in_tile;

  logic [DIM_W-1:0] w_clamped;
  logic [DIM_W-1:0] h_clamped;
  logic [TW:0]      pad_w;
  logic [TW:0]      pad_h;
  logic [TW:0]      col_inc;
  logic [TW:0]      row_inc;
  logic [CW-1:0]    x0;
  logic [CW-1:0]    y0;
  logic [CMPW-1:0]  x_rem;
  logic [CMPW-1:0]  y_rem;
  logic             x_in;
  logic             y_in;
  logic             accept;

  assign w_clamped = clamp_dim(cfg.image_width);
  assign h_clamped = clamp_dim(cfg.image_height);
  assign pad_w     = pad_tiles(w_clamped);
  assign pad_h     = pad_tiles(h_clamped);

  assign x0 = {tile_column, block_in_tile[0], 2'b00};
  assign y0 = {tile_row, block_in_tile[1], 2'b00};

  assign x_in  = CMPW'(x0) < CMPW'(w_clamped);
  assign y_in  = CMPW'(y0) < CMPW'(h_clamped);
  assign x_rem = CMPW'(w_clamped) - CMPW'(x0);
  assign y_rem = CMPW'(h_clamped) - CMPW'(y0);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // Drop blocks that lie wholly outside the image; the position still moves.
  assign q_push   = accept && x_in && y_in;

  always_comb begin
    logic [5:0]  hi;
    logic [4:0]  b5;
    logic [2:0]  d;
    logic [4:0]  s;
    logic [3:0]  n0;
    logic [3:0]  n1;
    q_cmd = '0;
    for (int ch = 0; ch < 3; ch++) begin
      hi = 6'(59 - 8 * ch);
      b5 = color_word[hi +: 5];
      d  = color_word[hi - 6'd3 +: 3];
      s  = b5 + {d[2], d[2], d};
      n0 = color_word[hi + 6'd1 +: 4];
      n1 = color_word[hi - 6'd3 +: 4];
      if (color_word[33]) begin
        q_cmd.base[0][ch] = {b5, b5[4:2]};
        q_cmd.base[1][ch] = {s, s[4:2]};
      end else begin
        q_cmd.base[0][ch] = {n0, n0};
        q_cmd.base[1][ch] = {n1, n1};
      end
    end
    q_cmd.tab[0]   = color_word[39:37];
    q_cmd.tab[1]   = color_word[36:34];
    q_cmd.flip     = color_word[32];
    q_cmd.pix_bits = color_word[31:0];
    q_cmd.alphas   = cfg.alpha_present ? alpha_word : {WORD_W{1'b1}};
    q_cmd.x0       = COORD_W'(x0);
    q_cmd.y0       = COORD_W'(y0);
    q_cmd.last_col = (x_rem >= CMPW'(4)) ? 2'd3 : (x_rem[1:0] - 2'd1);
    q_cmd.last_row = (y_rem >= CMPW'(4)) ? 2'd3 : (y_rem[1:0] - 2'd1);
  end

  assign col_inc = {1'b0, tile_column} + (TW+1)'(1);
  assign row_inc = {1'b0, tile_row} + (TW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_column   <= '0;
      tile_row      <= '0;
      block_in_tile <= '0;
    end else if (accept) begin
      block_in_tile <= block_in_tile + 2'd1;
      if (block_in_tile == 2'd3) begin
        if (col_inc >= pad_w) begin
          tile_column <= '0;
          if (row_inc >= pad_h) tile_row <= '0;
          else tile_row <= row_inc[TW-1:0];
        end else begin
          tile_column <= col_inc[TW-1:0];
        end
      end
    end
  end

endmodule

@@ hw/rtl/etc1_queue.sv @@
// Two-entry block queue between the front and back ends.
`timescale 1ns / 1ps

module etc1_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  etc1_pkg::etc1_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output etc1_pkg::etc1_cmd_t head_cmd
);
  import etc1_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  etc1_cmd_t     entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full       = count == (PW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/etc1_back.sv @@
// Back end: registers the head block's visible pixels out, one per cycle unless stalled.
`timescale 1ns / 1ps

module etc1_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  etc1_pkg::etc1_cmd_t head_cmd,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,
  output logic                m_tlast
);
  import etc1_pkg::*;

  logic [1:0]         col;
  logic [1:0]         row;
  logic               load;
  logic               last_col_hit;
  logic               last_row_hit;
  logic [3:0]         k;
  logic               half;
  logic [15:0]        sel_bits;
  logic [15:0]        sign_bits;
  logic [CH_W-1:0]    amt;
  logic [2:0][CH_W-1:0] rgb;
  logic [3:0]         a4;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;

  assign load         = head_valid && (!m_tvalid || m_tready);
  assign last_col_hit = col == head_cmd.last_col;
  assign last_row_hit = row == head_cmd.last_row;
  assign pop          = load && last_col_hit && last_row_hit;

  assign sel_bits  = head_cmd.pix_bits[15:0];
  assign sign_bits = head_cmd.pix_bits[31:16];

  assign k    = {col, row};
  assign half = head_cmd.flip ? row[1] : col[1];
  assign amt  = mod_amount(head_cmd.tab[half], sel_bits[k]);
  assign a4   = head_cmd.alphas[{k, 2'b00} +: 4];
  assign px   = {head_cmd.x0[COORD_W-1:2], col};
  assign py   = {head_cmd.y0[COORD_W-1:2], row};

  always_comb begin
    logic signed [9:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      if (sign_bits[k])
        v = $signed({2'b00, head_cmd.base[half][ch]}) - $signed({2'b00, amt});
      else
        v = $signed({2'b00, head_cmd.base[half][ch]}) + $signed({2'b00, amt});
      if (v < 0) rgb[ch] = 8'd0;
      else if (v > 10'sd255) rgb[ch] = 8'd255;
      else rgb[ch] = v[7:0];
    end
  end

  // Pixel walk: columns first, then rows, within the visible rectangle.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (load) begin
      if (last_col_hit) begin
        col <= '0;
        row <= last_row_hit ? 2'd0 : row + 2'd1;
      end else begin
        col <= col + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0000, a4, a4, rgb[2], rgb[1], rgb[0], py, px};
      m_tlast <= last_col_hit && last_row_hit;
    end
  end

endmodule

@@ hw/rtl/etc1_tiled_block_decoder_core.sv @@
// Top level of the ETC1 tiled block decoder: configuration registers and front/queue/back.
`timescale 1ns / 1ps

// Usage:
// Slave stream s_*: one compressed 4x4 block per item, color word in the low
// 64 bits, alpha word above it. Blocks arrive in tile order (8x8 tiles of
// 2x2 blocks); the block keeps the position itself and wraps after the last
// tile row. Master stream m_*: one decoded pixel per item with its image
// coordinates; m_tlast marks the last pixel of a block. Pixels outside the
// image are not sent, and a block wholly outside sends nothing.
// Configuration: wr_en/wr_index/wr_data set image width (0), image height
// (1) and alpha present (2); write them only while the block is idle.
// Flow: a taken block is written into the queue, and its pixels are then
// registered into the output register. The back end sends one pixel per cycle
// while m_tready is high; a clipped block sends only its visible pixels, and a
// block outside the image is dropped at the front. A two-block queue lets the
// next blocks be taken while pixels drain.
// Reset (rst, synchronous): width and height 8, no alpha, position at tile 0,
// block 0, queue and output empty. When m_tready is low the output holds and
// the queue fills; s_tready falls once two blocks wait.
module etc1_tiled_block_decoder_core #(
  parameter int MAX_DIMENSION = etc1_pkg::MAX_DIMENSION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [127:0]                  s_tdata,   // color_word[63:0], alpha_word[127:64]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [55:0]                   m_tdata,   // pixel_x, pixel_y, red, green, blue, alpha
  output logic                          m_tlast,   // last_pixel
  input  logic                          wr_en,
  input  logic [etc1_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [etc1_pkg::DIM_W-1:0]    wr_data
);
  import etc1_pkg::*;

  etc1_cfg_t cfg;
  etc1_cmd_t push_cmd;
  etc1_cmd_t head_cmd;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= WIDTH_RESET;
      cfg.image_height  <= HEIGHT_RESET;
      cfg.alpha_present <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_IMAGE_WIDTH:   cfg.image_width   <= wr_data;
        REG_IMAGE_HEIGHT:  cfg.image_height  <= wr_data;
        REG_ALPHA_PRESENT: cfg.alpha_present <= wr_data[0];
        default: ;
      endcase
    end
  end

  etc1_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .color_word (s_tdata[63:0]),
    .alpha_word (s_tdata[127:64]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  etc1_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  etc1_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

@@ bench/tb_etc1_tiled_block_decoder_core.sv @@
// Self-checking bench for the ETC1 tiled block decoder: block stream in, pixel stream checked.
`timescale 1ns / 1ps

module tb_etc1_tiled_block_decoder_core;
  import etc1_pkg::*;

  localparam int MAX_DIM     = MAX_DIMENSION_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 24;

  localparam logic [REG_IDX_W-1:0] REG_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
    logic [CH_W-1:0]    a;
    logic               last;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [127:0]         s_tdata = '0;   // color_word[63:0], alpha_word[127:64]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [55:0]          m_tdata;        // pixel_x, pixel_y, red, green, blue, alpha
  logic                 m_tlast;        // last_pixel
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [DIM_W-1:0]     wr_data = '0;

  etc1_tiled_block_decoder_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block's registers and position
  int img_w = 8;
  int img_h = 8;
  int img_alpha = 0;
  int tile_col = 0;
  int tile_row = 0;
  int blk_pos = 0;

  const int modifier[8][2] = '{'{2, 8}, '{5, 17}, '{9, 29}, '{13, 42},
                               '{18, 60}, '{24, 80}, '{33, 106}, '{47, 183}};

  logic [127:0] pending_blocks[$];
  pixel_t       pixel_q[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           no_idle = 1'b0;

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int padded_tiles(int dim);
    int tiles;
    int p;
    tiles = (dim + 7) / 8;
    p = 1;
    while (p < tiles) p = p * 2;
    return p;
  endfunction

  function automatic int expand5(int v);
    v = v & 31;
    return (v << 3) | (v >> 2);
  endfunction

  function automatic int sat8(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Decode one block at the current position, queue its visible pixels, advance
  function automatic void decode_block(input logic [127:0] item);
    logic [63:0] word;
    logic [63:0] alphas;
    int          w, h, hi, b5, d3, s5, cnt, x0, y0;
    int          base[2][3];
    int          tab[2];
    pixel_t      pix[16];
    word   = item[63:0];
    alphas = img_alpha ? item[127:64] : '1;
    w      = clamp_dim(img_w);
    h      = clamp_dim(img_h);
    tab[0] = int'(word[39:37]);
    tab[1] = int'(word[36:34]);
    for (int ch = 0; ch < 3; ch++) begin
      hi = 59 - 8 * ch;
      if (word[33]) begin
        b5 = int'((word >> hi) & 64'd31);
        d3 = int'((word >> (hi - 3)) & 64'd7);
        s5 = (b5 + d3 + ((d3 & 4) ? 24 : 0)) & 31;
        base[0][ch] = expand5(b5);
        base[1][ch] = expand5(s5);
      end else begin
        base[0][ch] = int'((word >> (hi + 1)) & 64'd15) * 17;
        base[1][ch] = int'((word >> (hi - 3)) & 64'd15) * 17;
      end
    end
    x0  = tile_col * 8 + (blk_pos & 1) * 4;
    y0  = tile_row * 8 + (blk_pos >> 1) * 4;
    cnt = 0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        int x, y, k, half, amt;
        x    = x0 + c;
        y    = y0 + r;
        k    = c * 4 + r;
        half = word[32] ? (r >> 1) : (c >> 1);
        if (x < w && y < h) begin
          amt = modifier[tab[half]][word[k]];
          if (word[16 + k]) amt = -amt;
          pix[cnt].x    = x[COORD_W-1:0];
          pix[cnt].y    = y[COORD_W-1:0];
          pix[cnt].r    = CH_W'(sat8(base[half][0] + amt));
          pix[cnt].g    = CH_W'(sat8(base[half][1] + amt));
          pix[cnt].b    = CH_W'(sat8(base[half][2] + amt));
          pix[cnt].a    = CH_W'(int'(alphas[4*k +: 4]) * 17);
          pix[cnt].last = 1'b0;
          cnt++;
        end
      end
    end
    if (cnt > 0) pix[cnt-1].last = 1'b1;
    for (int i = 0; i < cnt; i++) pixel_q.push_back(pix[i]);

    blk_pos = (blk_pos + 1) & 3;
    if (blk_pos == 0) begin
      tile_col++;
      if (tile_col >= padded_tiles(w)) begin
        tile_col = 0;
        tile_row++;
        if (tile_row >= padded_tiles(h)) tile_row = 0;
      end
    end
  endfunction

  // Block driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) decode_block(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          s_tdata  <= pending_blocks.pop_front();
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor
  int     stall_left = 0;
  int     hold_left = 0;
  int     pixels_seen = 0;
  pixel_t want;
  pixel_t got;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{x: m_tdata[9:0], y: m_tdata[19:10], r: m_tdata[27:20], g: m_tdata[35:28],
                b: m_tdata[43:36], a: m_tdata[51:44], last: m_tlast};
        pixels_seen++;
        // long hold so the queue fills and the input backs up
        if (pixels_seen == 150 || pixels_seen == 900) hold_left = 400;
        if (pixel_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected pixel x=%0d y=%0d rgba=%h%h%h%h last=%0b",
                     got.x, got.y, got.r, got.g, got.b, got.a, got.last);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("pixel mismatch: expected x=%0d y=%0d rgba=%h%h%h%h last=%0b,",
                       want.x, want.y, want.r, want.g, want.b, want.a, want.last,
                       " got x=%0d y=%0d rgba=%h%h%h%h last=%0b",
                       got.x, got.y, got.r, got.g, got.b, got.a, got.last);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        m_tready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= DIM_W'(val);
    case (idx)
      REG_IMAGE_WIDTH:   img_w = val & 'h7FF;
      REG_IMAGE_HEIGHT:  img_h = val & 'h7FF;
      REG_ALPHA_PRESENT: img_alpha = val & 1;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_image(input int w, input int h, input int a);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_ALPHA_PRESENT, a);
  endtask

  // Wait until every block is taken and every pixel is back, then let the core settle
  task automatic drain();
    while (pending_blocks.size() > 0 || s_tvalid || pixel_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] make_word(input logic [7:0] r, g, b,
                                            input logic [2:0] t0, t1,
                                            input logic diff, flip,
                                            input logic [31:0] lo);
    return {r, g, b, t0, t1, diff, flip, lo};
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) pending_blocks.push_back({rand64(), rand64()});
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed blocks at reset settings: 8x8 image, position wraps every four blocks
    pending_blocks.push_back({64'h0, 64'h0});
    pending_blocks.push_back({64'h0, {64{1'b1}}});
    pending_blocks.push_back({64'h0123456789ABCDEF,
                              make_word(8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd7, 1'b0, 1'b0,
                                        32'h0000FFFF)});
    pending_blocks.push_back({rand64(),
                              make_word(8'h00, 8'h00, 8'h00, 3'd7, 3'd7, 1'b0, 1'b1, '1)});
    // differential sums wrapping past 31 and below 0
    pending_blocks.push_back({rand64(),
                              make_word({5'd31, 3'd3}, {5'd30, 3'd2}, {5'd0, 3'd4},
                                        3'd6, 3'd5, 1'b1, 1'b0, $urandom)});
    pending_blocks.push_back({rand64(),
                              make_word({5'd1, 3'd4}, {5'd31, 3'd7}, {5'd28, 3'd3},
                                        3'd3, 3'd2, 1'b1, 1'b1, $urandom)});
    pending_blocks.push_back({rand64(),
                              make_word({5'd31, 3'd0}, {5'd0, 3'd0}, {5'd16, 3'd7},
                                        3'd0, 3'd1, 1'b1, 1'b0, 32'hFFFF0000)});
    for (int t = 0; t < 8; t++)
      pending_blocks.push_back({rand64(),
                                make_word(8'($urandom), 8'($urandom), 8'($urandom),
                                          3'(t), 3'(7 - t),
                                          1'($urandom), 1'($urandom), $urandom)});
    drain();

    // Alpha on, alpha extremes
    set_image(8, 8, 1);
    pending_blocks.push_back({64'h0, rand64()});
    pending_blocks.push_back({{64{1'b1}}, rand64()});
    pending_blocks.push_back({64'hFEDCBA9876543210, rand64()});
    pending_blocks.push_back({64'h0123456789ABCDEF, rand64()});
    push_random(10);
    drain();

    // Smallest image: most blocks lie wholly outside
    set_image(1, 1, 1);
    write_reg(REG_UNKNOWN, 'h7FF);
    push_random(12);
    drain();

    // Zero dimensions act as one
    set_image(0, 0, 0);
    push_random(8);
    drain();

    // Largest image, then an out-of-range width clamped to the maximum
    set_image(MAX_DIM, MAX_DIM, 1);
    push_random(14);
    drain();
    set_image(2047, 5, 0);
    write_reg(REG_UNKNOWN, 0);
    push_random(12);
    drain();

    // Narrower padded tile count: the kept column wraps at its next advance
    no_idle = 1'b1;
    set_image(13, 21, 1);
    push_random(24);
    drain();
    no_idle = 1'b0;

    for (int p = 0; p < 4; p++) begin
      set_image($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 1));
      push_random(6);
      drain();
    end

    set_image(9, 9, 1);
    push_random(8);
    drain();

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pixel_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/etc1_pkg.sv
hw/rtl/etc1_front.sv
hw/rtl/etc1_queue.sv
hw/rtl/etc1_back.sv
hw/rtl/etc1_tiled_block_decoder_core.sv
bench/tb_etc1_tiled_block_decoder_core.sv
